// ----- sv/ccl_pkg.sv -----
// Shared constants and types of the chunk cache tag and replacement controller.
// Used by the channel interfaces, the top level and its checker.
package ccl_pkg;

  localparam int unsigned WAYS        = 8;
  localparam int unsigned WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CHUNK_SIDE  = 16;
  localparam int unsigned OFF_W       = $clog2(CHUNK_SIDE);
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned CHUNK_W     = COORD_W - OFF_W;
  localparam int unsigned CFG_W       = 17;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned STAMP_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     MAP_RESET      = CFG_W'(4096);

  localparam logic ACT_PROBE = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } ccl_state_e;

endpackage

// ----- sv/ccl_if.sv -----
// Valid/ready channel interfaces for request and result beats.
// Depends on ccl_pkg for field widths.
interface ccl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [ccl_pkg::COORD_W-1:0]   tile_x;
  logic [ccl_pkg::COORD_W-1:0]   tile_y;

  modport source (output valid, action, tile_x, tile_y, input ready);
  modport sink   (input valid, action, tile_x, tile_y, output ready);
endinterface

interface ccl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          tile_ready;
  logic                          filled;
  logic [ccl_pkg::WAY_W-1:0]     slot;
  logic [ccl_pkg::CHUNK_W-1:0]   chunk_col;
  logic [ccl_pkg::CHUNK_W-1:0]   chunk_row;
  logic [ccl_pkg::OFF_W-1:0]     offset_x;
  logic [ccl_pkg::OFF_W-1:0]     offset_y;

  modport source (output valid, hit, tile_ready, filled, slot, chunk_col, chunk_row,
                  offset_x, offset_y, input ready);
  modport sink   (input valid, hit, tile_ready, filled, slot, chunk_col, chunk_row,
                  offset_x, offset_y, output ready);
endinterface

// ----- sv/chunk_cache_lru_lookup.sv -----
// Chunk cache tag lookup and LRU way claim, one way examined per cycle.
// Depends on ccl_pkg and the channel interfaces in ccl_if.sv.
//
//   channel   dir  beat
//   in_i      in   action, tile_x, tile_y
//   out_o     out  hit, tile_ready, filled, slot, chunk_col, chunk_row, offset_x, offset_y
//   cfg_*     in   cfg_we_i, cfg_idx_i, cfg_wdata_i (map width, map height)
//
// A request passes through accept, one tag and stamp compare per way in the shared
// comparator, then an update step. The update step waits while the previous result
// beat is still held on out_o. in_i.ready is high only between requests. Reset
// empties all ways and clears the use counter; map bounds return to 4096 tiles.
module chunk_cache_lru_lookup (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ccl_in_if.sink                         in_i,
  ccl_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [ccl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ccl_pkg::CFG_W-1:0]      cfg_wdata_i
);

  ccl_pkg::ccl_state_e state_q, state_d;

  logic                            in_ready;
  logic                            scan_en;
  logic                            upd_en;
  logic                            scan_last;

  logic [ccl_pkg::WAY_W-1:0]       idx_q;
  logic                            act_q;
  logic [ccl_pkg::COORD_W-1:0]     tx_q, ty_q;
  logic                            found_q, have_inv_q, have_min_q;
  logic [ccl_pkg::WAY_W-1:0]       hit_way_q, victim_q;
  logic [ccl_pkg::STAMP_W-1:0]     oldest_q;

  logic [ccl_pkg::WAYS-1:0]        valid_q;
  logic [ccl_pkg::CHUNK_W-1:0]     col_q   [ccl_pkg::WAYS];
  logic [ccl_pkg::CHUNK_W-1:0]     row_q   [ccl_pkg::WAYS];
  logic [ccl_pkg::STAMP_W-1:0]     stamp_q [ccl_pkg::WAYS];
  logic [ccl_pkg::STAMP_W-1:0]     counter_q;
  logic [ccl_pkg::CFG_W-1:0]       mapw_q, maph_q;

  logic                            out_valid_q;
  logic                            o_hit_q, o_ready_q, o_filled_q;
  logic [ccl_pkg::WAY_W-1:0]       o_slot_q;
  logic [ccl_pkg::CHUNK_W-1:0]     o_col_q, o_row_q;
  logic [ccl_pkg::OFF_W-1:0]       o_offx_q, o_offy_q;

  logic [ccl_pkg::CHUNK_W-1:0]     col, row;
  logic                            cur_valid, cur_match, cur_older;
  logic [ccl_pkg::CFG_W-1:0]       base_x, base_y;
  logic                            claim, touch;
  logic [ccl_pkg::WAY_W-1:0]       slot;
  logic [ccl_pkg::STAMP_W-1:0]     stamp_next;

  assign col       = tx_q[ccl_pkg::COORD_W-1:ccl_pkg::OFF_W];
  assign row       = ty_q[ccl_pkg::COORD_W-1:ccl_pkg::OFF_W];
  assign cur_valid = valid_q[idx_q];
  assign cur_match = cur_valid && (col_q[idx_q] == col) && (row_q[idx_q] == row);
  assign cur_older = !have_min_q || (stamp_q[idx_q] < oldest_q);
  assign scan_last = (idx_q == ccl_pkg::WAY_W'(ccl_pkg::WAYS - 1));

  assign base_x     = ccl_pkg::CFG_W'({col, {ccl_pkg::OFF_W{1'b0}}});
  assign base_y     = ccl_pkg::CFG_W'({row, {ccl_pkg::OFF_W{1'b0}}});
  assign claim      = !found_q && (act_q == ccl_pkg::ACT_FETCH) &&
                      (base_x < mapw_q) && (base_y < maph_q);
  assign touch      = found_q || claim;
  assign slot       = found_q ? hit_way_q : (claim ? victim_q : '0);
  assign stamp_next = counter_q + ccl_pkg::STAMP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    scan_en  = 1'b0;
    upd_en   = 1'b0;
    case (state_q)
      ccl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          state_d = ccl_pkg::ST_SCAN;
        end
      end
      ccl_pkg::ST_SCAN: begin
        scan_en = 1'b1;
        if (scan_last) begin
          state_d = ccl_pkg::ST_UPDATE;
        end
      end
      ccl_pkg::ST_UPDATE: begin
        if (!out_valid_q || out_o.ready) begin
          upd_en  = 1'b1;
          state_d = ccl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ccl_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      counter_q   <= '0;
      mapw_q      <= ccl_pkg::MAP_RESET;
      maph_q      <= ccl_pkg::MAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == ccl_pkg::CFG_MAP_WIDTH)) begin
        mapw_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == ccl_pkg::CFG_MAP_HEIGHT)) begin
        maph_q <= cfg_wdata_i;
      end
      if (upd_en && touch) begin
        counter_q <= stamp_next;
      end
      if (upd_en && claim) begin
        valid_q[victim_q] <= 1'b1;
      end
      if (upd_en) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request, scan and way payload
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      act_q      <= in_i.action;
      tx_q       <= in_i.tile_x;
      ty_q       <= in_i.tile_y;
      idx_q      <= '0;
      found_q    <= 1'b0;
      have_inv_q <= 1'b0;
      have_min_q <= 1'b0;
      hit_way_q  <= '0;
      victim_q   <= '0;
      oldest_q   <= '0;
    end
    if (scan_en) begin
      if (!scan_last) begin
        idx_q <= idx_q + ccl_pkg::WAY_W'(1);
      end
      if (cur_match && !found_q) begin
        found_q   <= 1'b1;
        hit_way_q <= idx_q;
      end
      if (!have_inv_q) begin
        if (!cur_valid) begin
          have_inv_q <= 1'b1;
          victim_q   <= idx_q;
        end else if (cur_older) begin
          have_min_q <= 1'b1;
          oldest_q   <= stamp_q[idx_q];
          victim_q   <= idx_q;
        end
      end
    end
    if (upd_en) begin
      if (touch) begin
        stamp_q[slot] <= stamp_next;
      end
      if (claim) begin
        col_q[victim_q] <= col;
        row_q[victim_q] <= row;
      end
      o_hit_q    <= found_q;
      o_ready_q  <= touch;
      o_filled_q <= claim;
      o_slot_q   <= slot;
      o_col_q    <= col;
      o_row_q    <= row;
      o_offx_q   <= tx_q[ccl_pkg::OFF_W-1:0];
      o_offy_q   <= ty_q[ccl_pkg::OFF_W-1:0];
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.hit        = o_hit_q;
  assign out_o.tile_ready = o_ready_q;
  assign out_o.filled     = o_filled_q;
  assign out_o.slot       = o_slot_q;
  assign out_o.chunk_col  = o_col_q;
  assign out_o.chunk_row  = o_row_q;
  assign out_o.offset_x   = o_offx_q;
  assign out_o.offset_y   = o_offy_q;

endmodule

// ----- sv/ccl_checker.sv -----
// Port-level checks on the chunk cache lookup, attached by bind.
// Depends on ccl_pkg and the top level chunk_cache_lru_lookup.
module ccl_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        out_hit_i,
  input  logic                        out_tile_ready_i,
  input  logic                        out_filled_i,
  input  logic [ccl_pkg::WAY_W-1:0]   out_slot_i
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request accepted while previous still in progress");

  a_filled_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_filled_i) |-> (out_tile_ready_i && !out_hit_i))
    else $error("claimed way reported on a hit or without tile_ready");

  a_hit_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_hit_i) |-> out_tile_ready_i)
    else $error("hit without tile_ready");

  a_not_ready_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_tile_ready_i) |-> (out_slot_i == '0))
    else $error("slot nonzero on a not-ready result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_slot_i) &&
                                       $stable(out_hit_i) && $stable(out_filled_i)))
    else $error("stalled result beat changed");

endmodule

bind chunk_cache_lru_lookup ccl_checker u_ccl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_hit_i        (out_o.hit),
  .out_tile_ready_i (out_o.tile_ready),
  .out_filled_i     (out_o.filled),
  .out_slot_i       (out_o.slot)
);
